FILE: rtl/jcd_pkg.sv
// package: shared constants, codes and types of the jukes-cantor distance block
`default_nettype none
package jcd_pkg;

    // default longest sequence pair that the counters take
    localparam int unsigned MAX_LENGTH_DEF = 65536;

    // log2 format and scaling
    localparam int unsigned FRAC_BITS = 28;
    localparam int unsigned MANT_BITS = 31;
    localparam int unsigned EXP_BITS  = 5;
    localparam int unsigned LOG_BITS  = EXP_BITS + FRAC_BITS;
    localparam int unsigned SCALE_BITS = 30;
    localparam logic [SCALE_BITS-1:0] JC_SCALE = 30'd558195838;

    // result fields
    localparam int unsigned DIST_BITS  = 20;
    localparam int unsigned COUNT_BITS = 17;
    localparam int unsigned QUEUE_DEPTH = 2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAIRS = 2'd1;
    localparam logic [1:0] ST_SATURATE = 2'd2;

    // nucleotide letters
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // back end sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_ITER,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_OUT
    } t_back_state;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctl;

    // fold lower case onto upper case
    function automatic logic [7:0] fold_base(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CH_LOW_A:CH_LOW_Z]})
            r = c - CASE_GAP;
        return r;
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        return (c inside {CH_A, CH_C, CH_G, CH_T});
    endfunction

endpackage
`default_nettype wire

FILE: rtl/jcd_front.sv
// front end: classifies character pairs and keeps the pair and mismatch counts
`default_nettype none
module jcd_front
    import jcd_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int unsigned CW = $clog2(MAX_LENGTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_base_first,
    input  wire logic [7:0]    i_base_second,
    input  wire logic          i_final_pair,
    input  wire logic          i_q_full,
    output logic               o_stall,
    output logic               o_push,
    output logic [CW-1:0]      o_n,
    output logic [CW-1:0]      o_m
);

    logic [CW-1:0] r_n, r_m, n_n, n_m;
    logic [7:0]    a_f, b_f;
    logic          accept, count_it;

    // classify the pair
    always_comb begin
        a_f      = fold_base(i_base_first);
        b_f      = fold_base(i_base_second);
        o_stall  = i_q_full;
        accept   = i_valid && !o_stall;
        count_it = is_base(a_f) && is_base(b_f) && (r_n < CW'(MAX_LENGTH));
        n_n      = r_n + (count_it ? CW'(1) : CW'(0));
        n_m      = r_m + ((count_it && (a_f != b_f)) ? CW'(1) : CW'(0));
        o_push   = accept && i_final_pair;
        o_n      = n_n;
        o_m      = n_m;
    end

    // counters, cleared after each final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_m <= '0;
        end else if (accept) begin
            r_n <= i_final_pair ? '0 : n_n;
            r_m <= i_final_pair ? '0 : n_m;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jcd_queue.sv
// queue of finished count pairs between front and back end
`default_nettype none
module jcd_queue
    import jcd_pkg::*;
#(
    parameter int unsigned CW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [CW-1:0] i_n,
    input  wire logic [CW-1:0] i_m,
    output logic               o_full,
    input  wire t_q_ctl        i_ctl_pop,
    output t_q_ctl             o_ctl,
    output logic [CW-1:0]      o_n,
    output logic [CW-1:0]      o_m
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    logic [CW-1:0] r_qn [QUEUE_DEPTH];
    logic [CW-1:0] r_qm [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          pop;

    always_comb begin
        o_full      = (r_cnt == (PW+1)'(QUEUE_DEPTH));
        o_ctl.valid = (r_cnt != '0);
        o_ctl.pop   = 1'b0;
        pop         = i_ctl_pop.pop && o_ctl.valid;
        o_n         = r_qn[r_rd];
        o_m         = r_qm[r_rd];
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_qn[r_wr] <= i_n;
            r_qm[r_wr] <= i_m;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (pop)    r_rd <= r_rd + PW'(1);
            r_cnt <= r_cnt + (i_push ? (PW+1)'(1) : '0) - (pop ? (PW+1)'(1) : '0);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jcd_back.sv
// back end: iterative log2 of both terms, scaling, saturation and result register
`default_nettype none
module jcd_back
    import jcd_pkg::*;
#(
    parameter int unsigned CW = 17
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_q_ctl                i_q,
    output t_q_ctl                     o_q,
    input  wire logic [CW-1:0]         i_n,
    input  wire logic [CW-1:0]         i_m,
    input  wire logic                  i_stall,
    output logic                       o_valid,
    output logic [DIST_BITS-1:0]       o_distance_q4_16,
    output logic [1:0]                 o_result_status,
    output logic [COUNT_BITS-1:0]      o_compared_count
);

    localparam int unsigned VW = CW + 2;
    localparam int unsigned PLW = 17 + SCALE_BITS;
    localparam int unsigned HIW = LOG_BITS - 17;
    localparam int unsigned PHW = HIW + SCALE_BITS;

    t_back_state r_state, n_state;

    logic [CW-1:0]          r_n;
    logic [VW-1:0]          r_v3n, r_vden;
    logic [MANT_BITS-1:0]   r_y;
    logic [EXP_BITS-1:0]    r_k;
    logic [FRAC_BITS-1:0]   r_frac;
    logic [EXP_BITS-1:0]    r_cnt;
    logic                   r_pass;
    logic [LOG_BITS-1:0]    r_lnum, r_diff;
    logic [PLW-1:0]         r_plo;
    logic [PHW-1:0]         r_phi;
    logic [DIST_BITS-1:0]   r_dist;
    logic [1:0]             r_status;
    logic                   r_out_valid;
    logic [DIST_BITS-1:0]   r_o_dist;
    logic [1:0]             r_o_status;
    logic [COUNT_BITS-1:0]  r_o_count;

    logic [VW-1:0]          v4m, vden;
    logic [2*MANT_BITS-1:0] sq;
    logic [MANT_BITS:0]     sq_t;
    logic [FRAC_BITS-1:0]   frac_nx;
    logic [LOG_BITS-1:0]    lden;
    logic [63:0]            total;
    logic [63:0]            shifted;
    logic                   out_free;

    // arithmetic on the current registers
    always_comb begin
        v4m     = {i_m, 2'b00};
        vden    = r_v3n - r_vden;
        sq      = r_y * r_y;
        sq_t    = sq[2*MANT_BITS-1:MANT_BITS-1];
        frac_nx = {r_frac[FRAC_BITS-2:0], sq_t[MANT_BITS]};
        lden    = {r_k, frac_nx};
        total   = (64'(r_phi) << 17) + 64'(r_plo) + (64'd1 << 41);
        shifted = total >> 42;
        out_free = !r_out_valid || !i_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_q.valid) n_state = S_NORM;
            S_NORM:   begin
                if (r_status != ST_OK) n_state = S_OUT;
                else if (r_y[MANT_BITS-1]) n_state = S_ITER;
            end
            S_ITER:   if (r_cnt == '0) n_state = r_pass ? S_MUL_LO : S_NORM;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SUM;
            S_SUM:    n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // queue pop
    always_comb begin
        o_q.valid = 1'b0;
        o_q.pop   = (r_state == S_IDLE) && i_q.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n    <= i_n;
                r_vden <= v4m;
                r_pass <= 1'b0;
                r_dist <= '0;
                if (i_n == '0)
                    r_status <= ST_NO_PAIRS;
                else if (v4m >= ({i_n, 1'b0} + VW'(i_n)))
                    r_status <= ST_SATURATE;
                else
                    r_status <= ST_OK;
                r_v3n  <= {i_n, 1'b0} + VW'(i_n);
                r_y    <= MANT_BITS'({i_n, 1'b0} + VW'(i_n));
                r_k    <= EXP_BITS'(MANT_BITS - 1);
            end
            S_NORM: begin
                r_cnt <= EXP_BITS'(FRAC_BITS - 1);
                if (!r_y[MANT_BITS-1]) begin
                    r_y <= {r_y[MANT_BITS-2:0], 1'b0};
                    r_k <= r_k - EXP_BITS'(1);
                end
            end
            S_ITER: begin
                r_frac <= frac_nx;
                r_cnt  <= r_cnt - EXP_BITS'(1);
                // end of the first term: keep its log and load the second term
                if (r_cnt == '0 && !r_pass) begin
                    r_lnum <= lden;
                    r_pass <= 1'b1;
                    r_y    <= MANT_BITS'(vden);
                    r_k    <= EXP_BITS'(MANT_BITS - 1);
                end else begin
                    r_y <= sq_t[MANT_BITS] ? sq_t[MANT_BITS:1] : sq_t[MANT_BITS-1:0];
                    if (r_cnt == '0)
                        r_diff <= (r_lnum > lden) ? (r_lnum - lden) : '0;
                end
            end
            S_MUL_LO: r_plo <= r_diff[16:0] * JC_SCALE;
            S_MUL_HI: r_phi <= r_diff[LOG_BITS-1:17] * JC_SCALE;
            S_SUM: begin
                r_dist <= (shifted > 64'((1 << DIST_BITS) - 1))
                        ? {DIST_BITS{1'b1}} : shifted[DIST_BITS-1:0];
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_dist   <= r_dist;
            r_o_status <= r_status;
            r_o_count  <= COUNT_BITS'(r_n);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_distance_q4_16 = r_o_dist;
    assign o_result_status  = r_o_status;
    assign o_compared_count = r_o_count;

endmodule
`default_nettype wire

FILE: rtl/jukes_cantor_dna_distance.sv
// top level: jukes-cantor distance of two aligned dna sequences
//
//   channel | direction | handshake          | word
//   pairs   | in        | i_valid / o_stall  | base_first, base_second, final_pair
//   result  | out       | o_valid / i_stall  | distance_q4_16, result_status, compared_count
//
// one character pair is taken per cycle; the front only stalls when both
// queue slots hold finished sequences. a result's time in the back end is set by
// mantissa normalization and the one-bit-per-cycle log2 squaring loop run once for
// each of the two terms; a failing status skips the loop. reset is synchronous and
// clears counters, queue and result valid. a stalled result holds while new pairs keep counting.
`default_nettype none
module jukes_cantor_dna_distance
    import jcd_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_base_first,
    input  wire logic [7:0]            i_base_second,
    input  wire logic                  i_final_pair,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DIST_BITS-1:0]       o_distance_q4_16,
    output logic [1:0]                 o_result_status,
    output logic [COUNT_BITS-1:0]      o_compared_count
);

    localparam int unsigned CW = $clog2(MAX_LENGTH + 1);

    logic          push, q_full;
    logic [CW-1:0] f_n, f_m, q_n, q_m;
    t_q_ctl        q_ctl, b_ctl;

    jcd_front #(.MAX_LENGTH(MAX_LENGTH), .CW(CW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_base_first, .i_base_second, .i_final_pair,
        .i_q_full(q_full), .o_stall, .o_push(push), .o_n(f_n), .o_m(f_m)
    );

    jcd_queue #(.CW(CW)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_n(f_n), .i_m(f_m), .o_full(q_full),
        .i_ctl_pop(b_ctl), .o_ctl(q_ctl), .o_n(q_n), .o_m(q_m)
    );

    jcd_back #(.CW(CW)) u_back (
        .i_clk, .i_rst_n, .i_q(q_ctl), .o_q(b_ctl), .i_n(q_n), .i_m(q_m),
        .i_stall, .o_valid, .o_distance_q4_16, .o_result_status, .o_compared_count
    );

endmodule
`default_nettype wire

FILE: rtl/jcd_checker.sv
// port checker for the jukes-cantor distance block, bound to the top level
`default_nettype none
module jcd_checker
    import jcd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [DIST_BITS-1:0]  o_distance_q4_16,
    input wire logic [1:0]            o_result_status,
    input wire logic [COUNT_BITS-1:0] o_compared_count
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a failed distance carries zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_status != ST_OK |-> o_distance_q4_16 == '0)
        else $error("nonzero distance with failing status");

    // empty overlap reports zero pairs
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_status == ST_NO_PAIRS |-> o_compared_count == '0)
        else $error("no-overlap status with pairs counted");

    // a valid distance has compared pairs
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_status == ST_OK |-> o_compared_count != '0)
        else $error("valid distance with no pairs");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_distance_q4_16)
            && $stable(o_result_status) && $stable(o_compared_count))
        else $error("stalled result changed");

endmodule

bind jukes_cantor_dna_distance jcd_checker u_jcd_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_distance_q4_16,
    .o_result_status, .o_compared_count
);
`default_nettype wire
